[hdl/jsm_pkg.sv]
// shared types and constants for the joystick setting mode controller
package jsm_pkg;

  localparam int ADC_BITS   = 12;
  localparam int DIGIT_CNT  = 4;
  localparam int TIME_BITS  = 32;
  localparam int PERIOD_BITS = 16;

  localparam logic [ADC_BITS-1:0] ADC_MAX      = {ADC_BITS{1'b1}};
  localparam logic [ADC_BITS-1:0] EDGE_LOW     = ADC_BITS'(10);
  localparam logic [ADC_BITS-1:0] EDGE_HIGH    = ADC_MAX - ADC_BITS'(15);
  localparam logic [ADC_BITS-1:0] STICK_CENTRE = ADC_BITS'(1) << (ADC_BITS - 1);

  localparam logic [DIGIT_CNT-1:0] FREQ_DIGITS = 4'b1100;
  localparam logic [DIGIT_CNT-1:0] DUR_DIGITS  = 4'b0011;

  localparam logic [1:0] JS_NORMAL = 2'd0;
  localparam logic [1:0] JS_PROG   = 2'd1;

  localparam logic REG_PROG_EN      = 1'b0;
  localparam logic REG_BLINK_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FREQ   = 2'd1,
    MODE_DUR    = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_DEC_FREQ = 3'd1,
    CMD_INC_FREQ = 3'd2,
    CMD_DEC_DUR  = 3'd3,
    CMD_INC_DUR  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [1:0]           joystick_mode;
    logic [ADC_BITS-1:0]  x_sample;
    logic [ADC_BITS-1:0]  y_sample;
    logic [TIME_BITS-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]            display_mode;
    logic [2:0]            adjust_cmd;
    logic                  show_settings;
    logic [DIGIT_CNT-1:0]  blink_digits;
    logic [DIGIT_CNT-1:0]  blank_digits;
    logic                  force_joystick_normal;
  } out_t;

  typedef struct packed {
    logic                   programming_enable;
    logic [PERIOD_BITS-1:0] blink_period_ms;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    logic                  blink_active;
    logic                  blink_phase_on;
    logic [DIGIT_CNT-1:0]  digit_mask;
    logic [TIME_BITS-1:0]  last_toggle_ms;
    logic [ADC_BITS-1:0]   last_x;
    logic [ADC_BITS-1:0]   last_y;
  } st_t;

endpackage

[hdl/jsm_step.sv]
// next state and result for one joystick update
module jsm_step
  import jsm_pkg::*;
(
  input  st_t  cur,
  input  cfg_t cfg,
  input  in_t  req,
  output st_t  nxt,
  output out_t res
);

  logic [TIME_BITS-1:0] lt;
  logic [TIME_BITS-1:0] elapsed;
  logic [1:0]           js;
  logic                 forced;
  logic                 show;
  cmd_t                 cmd;
  logic [DIGIT_CNT-1:0] mask;
  mode_t                other_mode;
  cmd_t                 cmd_dec;
  cmd_t                 cmd_inc;
  logic                 x_edge;
  logic                 y_low_edge;
  logic                 y_high_edge;

  assign lt      = (req.now_ms < cur.last_toggle_ms) ? req.now_ms : cur.last_toggle_ms;
  assign elapsed = req.now_ms - lt;

  assign x_edge = ((req.x_sample < EDGE_LOW) || (req.x_sample > EDGE_HIGH)) &&
                  !((cur.last_x < EDGE_LOW) || (cur.last_x > EDGE_HIGH));
  assign y_low_edge  = (req.y_sample < EDGE_LOW) && (cur.last_y >= EDGE_LOW);
  assign y_high_edge = (req.y_sample > EDGE_HIGH) && (cur.last_y <= EDGE_HIGH);

  always_comb begin
    nxt = cur;
    nxt.last_toggle_ms = lt;
    cmd = CMD_NONE;
    show = 1'b0;
    forced = 1'b0;
    js = req.joystick_mode;
    mask = FREQ_DIGITS;
    other_mode = MODE_DUR;
    cmd_dec = CMD_DEC_FREQ;
    cmd_inc = CMD_INC_FREQ;

    // blink timer
    if (cur.blink_active && (elapsed > TIME_BITS'(cfg.blink_period_ms))) begin
      nxt.last_toggle_ms = req.now_ms;
      nxt.blink_phase_on = !cur.blink_phase_on;
    end

    if (!cfg.programming_enable) begin
      nxt.mode = MODE_NORMAL;
      js = JS_NORMAL;
      forced = 1'b1;
    end

    if (nxt.mode == MODE_DUR) begin
      mask = DUR_DIGITS;
      other_mode = MODE_FREQ;
      cmd_dec = CMD_DEC_DUR;
      cmd_inc = CMD_INC_DUR;
    end

    case (nxt.mode)
      MODE_NORMAL: begin
        if (js == JS_PROG) begin
          nxt.mode = MODE_DUR;
        end
      end
      MODE_FREQ, MODE_DUR: begin
        show = 1'b1;
        if (!cur.blink_active) begin
          nxt.blink_active = 1'b1;
          nxt.blink_phase_on = 1'b0;
          nxt.last_toggle_ms = req.now_ms;
        end
        nxt.digit_mask = mask;
        if (js == JS_NORMAL) begin
          nxt.digit_mask = '0;
          nxt.blink_active = 1'b0;
          nxt.mode = MODE_NORMAL;
        end else begin
          nxt.last_x = req.x_sample;
          nxt.last_y = req.y_sample;
          if (x_edge) begin
            nxt.mode = other_mode;
          end else if (y_low_edge) begin
            cmd = cmd_dec;
          end else if (y_high_edge) begin
            cmd = cmd_inc;
          end
        end
      end
      default: begin
      end
    endcase

    res.display_mode          = nxt.mode;
    res.adjust_cmd            = cmd;
    res.show_settings         = show;
    res.blink_digits          = nxt.digit_mask;
    res.blank_digits          = (nxt.blink_active && !nxt.blink_phase_on) ?
                                nxt.digit_mask : '0;
    res.force_joystick_normal = forced;
  end

endmodule

[hdl/joystick_setting_mode_fsm.sv]
// top level of the joystick setting mode controller
// Takes one joystick update per clock while the output side does not stall. A request is
// captured in an input register, worked out combinationally against the mode, blink and
// stick state, and its result lands in an output register when the output side can take
// it. One request per cycle is sustained while results are taken; the output register
// holds a result until it is taken while the input register keeps the next request.
// Configuration registers are written through the cfg port and take effect for requests
// processed afterward.
module joystick_setting_mode_fsm
  import jsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [PERIOD_BITS-1:0] cfg_wdata
);

  cfg_t cfg_r;
  st_t  st_r;
  st_t  st_nxt;
  in_t  req_r;
  logic req_valid_r;
  out_t res_nxt;
  out_t out_r;
  logic out_valid_r;
  logic advance;

  assign advance   = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !req_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  jsm_step u_step (
    .cur (st_r),
    .cfg (cfg_r),
    .req (req_r),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.programming_enable <= 1'b0;
      cfg_r.blink_period_ms    <= PERIOD_BITS'(500);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROG_EN:      cfg_r.programming_enable <= cfg_wdata[0];
        REG_BLINK_PERIOD: cfg_r.blink_period_ms    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= MODE_NORMAL;
      st_r.blink_active   <= 1'b0;
      st_r.blink_phase_on <= 1'b0;
      st_r.digit_mask     <= '0;
      st_r.last_toggle_ms <= '0;
      st_r.last_x         <= STICK_CENTRE;
      st_r.last_y         <= STICK_CENTRE;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

endmodule

[test/joystick_setting_mode_fsm_tb.sv]
// self-checking testbench for the joystick setting mode controller
`timescale 1ns / 100ps

module joystick_setting_mode_fsm_tb;
  import jsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN = 300;
  localparam int MAX_PRINTS = 50;
  localparam logic [1:0] JS_OTHER = 2'd2;
  localparam logic [1:0] JS_THREE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic [PERIOD_BITS-1:0] cfg_wdata = '0;

  joystick_setting_mode_fsm dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predicted controller state and registers
  logic prog_en;
  logic [PERIOD_BITS-1:0] blink_period;
  mode_t cur_mode;
  logic blink_on;
  logic phase_on;
  logic [DIGIT_CNT-1:0] digit_mask;
  logic [TIME_BITS-1:0] last_toggle;
  logic [ADC_BITS-1:0] last_x;
  logic [ADC_BITS-1:0] last_y;

  in_t update_q[$];
  out_t display_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_cnt = 0;
  int error_cnt = 0;
  int cycle_cnt = 0;
  logic [TIME_BITS-1:0] gen_time = '0;

  logic drv_valid;
  in_t drv_data;
  out_t drv_res;

  function automatic logic off_band(input logic [ADC_BITS-1:0] v);
    return (v < EDGE_LOW) || (v > EDGE_HIGH);
  endfunction

  task automatic step_settings(input in_t rq, output out_t res);
    logic [1:0] js;
    logic [TIME_BITS-1:0] now;
    logic [ADC_BITS-1:0] px;
    logic [ADC_BITS-1:0] py;
    logic [DIGIT_CNT-1:0] mask;
    mode_t other;
    cmd_t dec_cmd;
    cmd_t inc_cmd;
    cmd_t cmd;
    logic show;
    logic forced;
    js = rq.joystick_mode;
    now = rq.now_ms;
    cmd = CMD_NONE;
    show = 1'b0;
    forced = 1'b0;
    if (now < last_toggle) last_toggle = now;
    if (blink_on && (now - last_toggle) > {16'b0, blink_period}) begin
      last_toggle = now;
      phase_on = ~phase_on;
    end
    if (!prog_en) begin
      cur_mode = MODE_NORMAL;
      js = JS_NORMAL;
      forced = 1'b1;
    end
    if (cur_mode == MODE_NORMAL) begin
      if (js == JS_PROG) cur_mode = MODE_DUR;
    end else if (cur_mode == MODE_FREQ || cur_mode == MODE_DUR) begin
      show = 1'b1;
      if (cur_mode == MODE_FREQ) begin
        mask = FREQ_DIGITS;
        other = MODE_DUR;
        dec_cmd = CMD_DEC_FREQ;
        inc_cmd = CMD_INC_FREQ;
      end else begin
        mask = DUR_DIGITS;
        other = MODE_FREQ;
        dec_cmd = CMD_DEC_DUR;
        inc_cmd = CMD_INC_DUR;
      end
      if (!blink_on) begin
        blink_on = 1'b1;
        phase_on = 1'b0;
        last_toggle = now;
      end
      digit_mask = mask;
      if (js == JS_NORMAL) begin
        digit_mask = '0;
        blink_on = 1'b0;
        cur_mode = MODE_NORMAL;
      end else begin
        px = last_x;
        py = last_y;
        last_x = rq.x_sample;
        last_y = rq.y_sample;
        if (off_band(rq.x_sample) && !off_band(px)) cur_mode = other;
        else if (rq.y_sample < EDGE_LOW && py >= EDGE_LOW) cmd = dec_cmd;
        else if (rq.y_sample > EDGE_HIGH && py <= EDGE_HIGH) cmd = inc_cmd;
      end
    end
    res.display_mode = cur_mode;
    res.adjust_cmd = cmd;
    res.show_settings = show;
    res.blink_digits = digit_mask;
    res.blank_digits = (blink_on && !phase_on) ? digit_mask : '0;
    res.force_joystick_normal = forced;
  endtask

  task automatic report_error(input string msg);
    if (error_cnt < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    error_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // driver: one update per handshake, valid held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_valid = in_valid;
      drv_data = in_data;
      if (in_valid && in_ready) begin
        step_settings(in_data, drv_res);
        display_q.push_back(drv_res);
        drv_valid = 1'b0;
      end
      if (!drv_valid && update_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_data = update_q.pop_front();
        drv_valid = 1'b1;
      end
      in_valid <= drv_valid;
      in_data <= drv_data;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_cnt <= HOLD_LEN;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: compares each taken result against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (display_q.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          drv_res = display_q.pop_front();
          check_field("display_mode", 32'(out_data.display_mode),
                      32'(drv_res.display_mode));
          check_field("adjust_cmd", 32'(out_data.adjust_cmd), 32'(drv_res.adjust_cmd));
          check_field("show_settings", 32'(out_data.show_settings),
                      32'(drv_res.show_settings));
          check_field("blink_digits", 32'(out_data.blink_digits),
                      32'(drv_res.blink_digits));
          check_field("blank_digits", 32'(out_data.blank_digits),
                      32'(drv_res.blank_digits));
          check_field("force_joystick_normal", 32'(out_data.force_joystick_normal),
                      32'(drv_res.force_joystick_normal));
        end
      end
      if (hold_cnt > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("joystick_setting_mode_fsm_tb: errors");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] js, input logic [ADC_BITS-1:0] x,
                          input logic [ADC_BITS-1:0] y, input logic [TIME_BITS-1:0] t);
    in_t it;
    it.joystick_mode = js;
    it.x_sample = x;
    it.y_sample = y;
    it.now_ms = t;
    update_q.push_back(it);
  endtask

  task automatic drain();
    while (update_q.size() != 0 || in_valid || display_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PERIOD_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_PROG_EN) prog_en = val[0];
    else blink_period = val;
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 50) return ADC_BITS'($urandom_range(EDGE_LOW, EDGE_HIGH));
    if (r < 70) return ADC_BITS'($urandom_range(0, EDGE_LOW - 1));
    if (r < 90) return ADC_BITS'($urandom_range(EDGE_HIGH + 1, ADC_MAX));
    return ADC_BITS'($urandom);
  endfunction

  // mostly edit sessions: enter, wiggle the stick, occasionally leave
  task automatic queue_random(input int n);
    int r;
    logic [1:0] js;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10) js = JS_NORMAL;
      else if (r < 25) js = JS_PROG;
      else if (r < 90) js = JS_OTHER;
      else js = JS_THREE;
      r = $urandom_range(99);
      if (r < 3) gen_time = $urandom;
      else if (r < 5) gen_time = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else if (r < 8) gen_time += $urandom_range(0, 70000);
      else gen_time += $urandom_range(0, 60);
      push_req(js, pick_sample(), pick_sample(), gen_time);
    end
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    prog_en = 1'b0;
    blink_period = 16'd500;
    cur_mode = MODE_NORMAL;
    blink_on = 1'b0;
    phase_on = 1'b0;
    digit_mask = '0;
    last_toggle = '0;
    last_x = STICK_CENTRE;
    last_y = STICK_CENTRE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // programming disabled out of reset
    push_req(JS_PROG, 12'd2048, 12'd2048, 32'd10);
    push_req(JS_OTHER, 12'd4095, 12'd0, 32'd20);
    drain();
    write_reg(REG_PROG_EN, 16'd1);
    write_reg(REG_BLINK_PERIOD, 16'd5);
    @(negedge clk);
    push_req(JS_NORMAL, 12'd2048, 12'd2048, 32'd30);
    push_req(JS_THREE, 12'd2048, 12'd2048, 32'd31);
    push_req(JS_PROG, 12'd2048, 12'd2048, 32'd32);
    push_req(JS_OTHER, 12'd2048, 12'd2048, 32'd33);
    push_req(JS_OTHER, 12'd4095, 12'd2048, 32'd34);
    push_req(JS_OTHER, 12'd2048, 12'd0, 32'd40);
    push_req(JS_OTHER, 12'd2048, 12'd4095, 32'd41);
    push_req(JS_THREE, 12'd0, 12'd4095, 32'd42);
    push_req(JS_OTHER, 12'd2048, 12'd9, 32'd50);
    push_req(JS_PROG, 12'd2048, 12'd4081, 32'd51);
    push_req(JS_OTHER, 12'd10, 12'd10, 32'd52);
    push_req(JS_OTHER, 12'd4080, 12'd4080, 32'd53);
    push_req(JS_OTHER, 12'd9, 12'd2048, 32'd60);
    push_req(JS_OTHER, 12'd4081, 12'd2048, 32'd61);
    push_req(JS_OTHER, 12'd2048, 12'd2048, 32'hFFFF_FFFF);
    push_req(JS_OTHER, 12'd2048, 12'd2048, 32'd0);
    push_req(JS_NORMAL, 12'd2048, 12'd2048, 32'd1);
    push_req(JS_PROG, 12'd2048, 12'd2048, 32'd2);
    push_req(JS_OTHER, 12'd2048, 12'd2048, 32'd3);
    drain();
    // disable programming while in an edit mode
    write_reg(REG_PROG_EN, 16'd0);
    @(negedge clk);
    push_req(JS_OTHER, 12'd4095, 12'd4095, 32'd10);
    push_req(JS_PROG, 12'd2048, 12'd2048, 32'd20);
    drain();
    write_reg(REG_BLINK_PERIOD, 16'hFFFF);
    write_reg(REG_PROG_EN, 16'd1);
    @(negedge clk);
    push_req(JS_PROG, 12'd2048, 12'd2048, 32'd30);
    push_req(JS_OTHER, 12'd2048, 12'd2048, 32'd70000);
    gen_time = 32'd70000;
    drain();

    // back-to-back with a long output hold-off
    write_reg(REG_BLINK_PERIOD, 16'd500);
    @(negedge clk);
    set_idle(0, 0);
    queue_random(400);
    hold_requests++;
    drain();

    write_reg(REG_BLINK_PERIOD, 16'd0);
    @(negedge clk);
    set_idle(86, 0);
    queue_random(300);
    drain();

    write_reg(REG_BLINK_PERIOD, 16'hFFFF);
    @(negedge clk);
    set_idle(0, 86);
    queue_random(300);
    drain();

    write_reg(REG_BLINK_PERIOD, 16'($urandom_range(1, 200)));
    @(negedge clk);
    set_idle(25, 25);
    queue_random(300);
    drain();

    write_reg(REG_PROG_EN, 16'd0);
    @(negedge clk);
    set_idle(0, 0);
    queue_random(100);
    drain();

    write_reg(REG_PROG_EN, 16'd1);
    write_reg(REG_BLINK_PERIOD, 16'd3);
    @(negedge clk);
    set_idle(25, 25);
    queue_random(150);
    drain();

    if (error_cnt == 0) begin
      $display("joystick_setting_mode_fsm_tb: clean");
    end else begin
      $display("joystick_setting_mode_fsm_tb: errors");
    end
    $finish;
  end

endmodule
